// File: hdl/sfq_pkg.sv
// Shared types and constants for the servo fault qualifier.
package sfq_pkg;

    localparam logic [31:0] STALE_MS = 32'd400;
    localparam logic [15:0] SAT16    = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_OK    = 2'd0,
        KIND_STALL = 2'd1,
        KIND_HW    = 2'd2,
        KIND_HEAT  = 2'd3
    } kind_t;

    // Classification made at the front; priority there is HW, then HEAT, then STALL, else CLEAN.
    typedef enum logic [1:0] {
        CLS_CLEAN = 2'd0,
        CLS_STALL = 2'd1,
        CLS_HW    = 2'd2,
        CLS_HEAT  = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        REG_LAG_LIMIT      = 3'd0,
        REG_LOAD_LIMIT     = 3'd1,
        REG_CURRENT_LIMIT  = 3'd2,
        REG_STALL_WINDOW   = 3'd3,
        REG_OVERHEAT_LIMIT = 3'd4,
        REG_IMPLAUS_TEMP   = 3'd5,
        REG_CONFIRM_WINDOW = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] lag_limit;
        logic [15:0] load_limit;
        logic [15:0] current_limit;
        logic [15:0] stall_window_ms;
        logic [7:0]  overheat_limit;
        logic [7:0]  implausible_temp;
        logic [15:0] confirm_window_ms;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [7:0]         joint_id;
        logic [15:0]        target_pos;
        logic [15:0]        actual_pos;
        logic signed [15:0] load_value;
        logic signed [15:0] current_value;
        logic [7:0]         temperature;
        logic [7:0]         hw_error_bits;
        logic [31:0]        time_ms;
    } sample_t;

    typedef struct packed {
        logic        tripped;
        logic [1:0]  fault_kind;
        logic [15:0] abs_error;
        logic [15:0] held_ms;
        logic        watching;
        logic [7:0]  watched_servo;
        logic [15:0] peak_error;
        logic [15:0] stall_drops;
        logic [15:0] bad_temp_count;
    } result_t;

    // Classified transaction as it waits in the queue.
    typedef struct packed {
        logic        clear;
        logic [7:0]  joint_id;
        logic [15:0] err;
        logic [31:0] time_ms;
        cls_t        cls;
        logic        bad_temp;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: hdl/servo_fault_qualifier_top.sv
// Top level of the servo fault qualifier: configuration registers and block wiring.
// A sample accepted is written into the queue, then passes through the tracker into the
// result register. Throughput: one transaction per cycle unless a stall holds the flow;
// the QUEUE_DEPTH-entry queue absorbs result stall.
// Reset (rst_n low, asynchronous): registers take their default thresholds, no
// fault, no candidate, counters and peak at zero, queue and result empty.
module servo_fault_qualifier_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfq_pkg::sample_t  sample,
    input  logic              sample_valid,
    output logic              sample_stall,
    output sfq_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    sfq_pkg::cfg_t          cfg_reg;
    sfq_pkg::queue_status_t qstat;
    sfq_pkg::item_t         push_item;
    sfq_pkg::item_t         head;
    logic                   push;
    logic                   pop;

    // Register writes always taken; software writes only while idle, not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lag_limit         <= 16'd240;
            cfg_reg.load_limit        <= 16'd500;
            cfg_reg.current_limit     <= 16'd700;
            cfg_reg.stall_window_ms   <= 16'd150;
            cfg_reg.overheat_limit    <= 8'd70;
            cfg_reg.implausible_temp  <= 8'd100;
            cfg_reg.confirm_window_ms <= 16'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfq_pkg::REG_LAG_LIMIT:      cfg_reg.lag_limit         <= cfg_data;
                sfq_pkg::REG_LOAD_LIMIT:     cfg_reg.load_limit        <= cfg_data;
                sfq_pkg::REG_CURRENT_LIMIT:  cfg_reg.current_limit     <= cfg_data;
                sfq_pkg::REG_STALL_WINDOW:   cfg_reg.stall_window_ms   <= cfg_data;
                sfq_pkg::REG_OVERHEAT_LIMIT: cfg_reg.overheat_limit    <= cfg_data[7:0];
                sfq_pkg::REG_IMPLAUS_TEMP:   cfg_reg.implausible_temp  <= cfg_data[7:0];
                sfq_pkg::REG_CONFIRM_WINDOW: cfg_reg.confirm_window_ms <= cfg_data;
                default:                     ; // unmapped index: drop the write
            endcase
        end
    end

    // Classify the incoming transaction against the thresholds.
    sfq_front u_front
    (
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .push         (push),
        .item         (push_item)
    );

    // Hold classified transactions so each side can stall on its own.
    sfq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Advance the candidate and fault latch, and register the result.
    sfq_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// File: hdl/sfq_front.sv
// Front end: accept samples and classify them against the thresholds.
module sfq_front
(
    input  sfq_pkg::sample_t       sample,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sfq_pkg::cfg_t          cfg,
    input  sfq_pkg::queue_status_t qstat,
    output logic                   push,
    output sfq_pkg::item_t         item
);

    logic [15:0] err;
    logic [16:0] load_neg;
    logic [16:0] cur_neg;
    logic [15:0] load_mag;
    logic [15:0] cur_mag;
    logic        usable;
    logic        heat;
    logic        lag;
    logic        strain;

    assign sample_stall = qstat.full;
    assign push         = sample_valid && !qstat.full;

    always_comb
    begin
        err = (sample.actual_pos >= sample.target_pos)
            ? sample.actual_pos - sample.target_pos
            : sample.target_pos - sample.actual_pos;

        // magnitude of a signed 16-bit value; the most negative value maps to 0x8000
        load_neg = 17'h10000 - {1'b0, sample.load_value};
        cur_neg  = 17'h10000 - {1'b0, sample.current_value};
        load_mag = sample.load_value[15] ? load_neg[15:0] : sample.load_value;
        cur_mag  = sample.current_value[15] ? cur_neg[15:0] : sample.current_value;

        usable = (cfg.implausible_temp == 8'd0) || (sample.temperature < cfg.implausible_temp);
        heat   = usable && (cfg.overheat_limit != 8'd0)
              && (sample.temperature >= cfg.overheat_limit);
        lag    = err >= cfg.lag_limit;
        strain = (load_mag >= cfg.load_limit) || (cur_mag >= cfg.current_limit);

        item.clear    = sample.mode;
        item.joint_id = sample.joint_id;
        item.err      = err;
        item.time_ms  = sample.time_ms;
        item.bad_temp = !usable;
        if (sample.hw_error_bits != 8'd0)
        begin
            item.cls = sfq_pkg::CLS_HW;
        end
        else if (heat)
        begin
            item.cls = sfq_pkg::CLS_HEAT;
        end
        else if (lag && strain)
        begin
            item.cls = sfq_pkg::CLS_STALL;
        end
        else
        begin
            item.cls = sfq_pkg::CLS_CLEAN;
        end
    end

endmodule

// File: hdl/sfq_queue.sv
// Short register queue between the classifier and the fault tracker.
module sfq_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sfq_pkg::item_t         push_item,
    input  logic                   pop,
    output sfq_pkg::item_t         head,
    output sfq_pkg::queue_status_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

    sfq_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign qstat.full  = (count_reg == DEPTH_C);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/sfq_back.sv
// Back end: candidate tracking, fault latch, counters and the result register.
module sfq_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfq_pkg::cfg_t          cfg,
    input  sfq_pkg::item_t         head,
    input  sfq_pkg::queue_status_t qstat,
    output logic                   pop,
    output sfq_pkg::result_t       result,
    output logic                   result_valid,
    input  logic                   result_stall
);

    sfq_pkg::kind_t   latched_reg, latched_next;
    logic [7:0]       cand_servo_reg, cand_servo_next;
    sfq_pkg::kind_t   cand_kind_reg, cand_kind_next;
    logic [31:0]      cand_since_reg, cand_since_next;
    logic [31:0]      cand_last_reg, cand_last_next;
    logic [15:0]      peak_reg, peak_next;
    logic [15:0]      drops_reg, drops_next;
    logic [15:0]      bad_reg, bad_next;
    logic             valid_reg;
    sfq_pkg::result_t result_reg, result_next;

    logic             stale;
    logic [7:0]       eff_servo;
    sfq_pkg::kind_t   eff_kind;
    sfq_pkg::kind_t   track_kind;
    logic [31:0]      held;
    logic [31:0]      need;
    logic [31:0]      idle_ms;
    logic             tripped;
    logic [15:0]      held_out;
    logic             watch;

    assign pop          = !qstat.empty && (!valid_reg || !result_stall);
    assign result       = result_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        latched_next    = latched_reg;
        cand_servo_next = cand_servo_reg;
        cand_kind_next  = cand_kind_reg;
        cand_since_next = cand_since_reg;
        cand_last_next  = cand_last_reg;
        peak_next       = peak_reg;
        drops_next      = drops_reg;
        bad_next        = bad_reg;
        tripped         = 1'b0;
        held_out        = 16'd0;

        idle_ms   = head.time_ms - cand_last_reg;
        stale     = (cand_servo_reg != 8'd0) && (idle_ms > sfq_pkg::STALE_MS);
        eff_servo = stale ? 8'd0 : cand_servo_reg;
        eff_kind  = stale ? sfq_pkg::KIND_OK : cand_kind_reg;
        held      = head.time_ms - cand_since_reg;

        case (head.cls)
            sfq_pkg::CLS_HW:    track_kind = sfq_pkg::KIND_HW;
            sfq_pkg::CLS_HEAT:  track_kind = sfq_pkg::KIND_HEAT;
            sfq_pkg::CLS_STALL: track_kind = sfq_pkg::KIND_STALL;
            default:            track_kind = sfq_pkg::KIND_OK;
        endcase
        need = (head.cls == sfq_pkg::CLS_STALL) ? {16'd0, cfg.stall_window_ms}
                                                : {16'd0, cfg.confirm_window_ms};

        if (head.clear)
        begin
            latched_next    = sfq_pkg::KIND_OK;
            cand_servo_next = 8'd0;
            cand_kind_next  = sfq_pkg::KIND_OK;
            cand_since_next = 32'd0;
            cand_last_next  = 32'd0;
        end
        else if (latched_reg == sfq_pkg::KIND_OK)
        begin
            if (head.err > peak_reg)
            begin
                peak_next = head.err;
            end
            cand_servo_next = eff_servo;
            cand_kind_next  = eff_kind;
            if (head.bad_temp && (bad_reg != sfq_pkg::SAT16))
            begin
                bad_next = bad_reg + 16'd1;
            end

            if (head.cls == sfq_pkg::CLS_CLEAN)
            begin
                // drop the candidate of this servo on a clean sample
                if (eff_servo == head.joint_id)
                begin
                    if ((eff_kind == sfq_pkg::KIND_STALL) && (drops_reg != sfq_pkg::SAT16))
                    begin
                        drops_next = drops_reg + 16'd1;
                    end
                    cand_servo_next = 8'd0;
                    cand_kind_next  = sfq_pkg::KIND_OK;
                end
            end
            else if ((eff_servo != head.joint_id) || (eff_kind != track_kind))
            begin
                cand_servo_next = head.joint_id;
                cand_kind_next  = track_kind;
                cand_since_next = head.time_ms;
                cand_last_next  = head.time_ms;
            end
            else
            begin
                cand_last_next = head.time_ms;
                if (held >= need)
                begin
                    latched_next = track_kind;
                    tripped      = 1'b1;
                    if (head.cls == sfq_pkg::CLS_STALL)
                    begin
                        held_out = (held > {16'd0, sfq_pkg::SAT16}) ? sfq_pkg::SAT16
                                                                     : held[15:0];
                    end
                    else
                    begin
                        held_out = held[15:0];
                    end
                end
            end
        end

        watch = (latched_next == sfq_pkg::KIND_OK) && (cand_servo_next != 8'd0);

        result_next.tripped        = tripped;
        result_next.fault_kind     = latched_next;
        result_next.abs_error      = head.clear ? 16'd0 : head.err;
        result_next.held_ms        = held_out;
        result_next.watching       = watch;
        result_next.watched_servo  = watch ? cand_servo_next : 8'd0;
        result_next.peak_error     = peak_next;
        result_next.stall_drops    = drops_next;
        result_next.bad_temp_count = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg    <= sfq_pkg::KIND_OK;
            cand_servo_reg <= 8'd0;
            cand_kind_reg  <= sfq_pkg::KIND_OK;
            cand_since_reg <= 32'd0;
            cand_last_reg  <= 32'd0;
            peak_reg       <= 16'd0;
            drops_reg      <= 16'd0;
            bad_reg        <= 16'd0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                latched_reg    <= latched_next;
                cand_servo_reg <= cand_servo_next;
                cand_kind_reg  <= cand_kind_next;
                cand_since_reg <= cand_since_next;
                cand_last_reg  <= cand_last_next;
                peak_reg       <= peak_next;
                drops_reg      <= drops_next;
                bad_reg        <= bad_next;
                valid_reg      <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: hdl/sfq_checker.sv
// Port-level checks for the servo fault qualifier and their bind.
module sfq_checker
(
    input logic             clk,
    input logic             rst_n,
    input sfq_pkg::result_t result,
    input logic             result_valid,
    input logic             result_stall
);

    a_trip_latches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tripped |-> result.fault_kind != sfq_pkg::KIND_OK)
        else $error("tripped result without a latched fault");

    a_watch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.watching
        |-> result.fault_kind == sfq_pkg::KIND_OK && result.watched_servo != 8'd0)
        else $error("watching reported with a fault or no servo");

    a_no_watch_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.watching |-> result.watched_servo == 8'd0)
        else $error("watched servo shown while not watching");

    a_held_trip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.held_ms != 16'd0 |-> result.tripped)
        else $error("hold time shown without a trip");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind servo_fault_qualifier_top sfq_checker u_sfq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
